FILE: design/assert_macros.svh
// Assertion macros for the frame builder. Clock clk, reset arst_n are taken from scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LPFB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define LPFB_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define LPFB_ASSERT(lbl, prop, msg)
`define LPFB_NEVER(lbl, cond, msg)
`endif
`endif

FILE: design/lpfb_pkg.sv
package lpfb_pkg;

	localparam int MAX_LEN = 1024;
	localparam logic [15:0] LEN_LIMIT = 16'(MAX_LEN - 10);
	localparam logic [15:0] OPC_OVERHEAD = 16'd5;
	localparam logic [15:0] UNI_OVERHEAD = 16'd3;

	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);

	typedef enum logic [1:0] {
		J_OPC,
		J_UNI,
		J_PAY,
		J_REJ
	} jtype_t;

	// one queued job: a frame header, one payload byte or a rejection
	typedef struct packed {
		jtype_t      jtype;
		logic [15:0] total;
		logic [15:0] opcode;
		logic        has_data;
		logic        last;
		logic [7:0]  data;
	} job_t;

endpackage

FILE: design/lpfb_in_if.sv
interface lpfb_in_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [15:0] opcode;
	logic [15:0] payload_len;
	logic        first;
	logic [7:0]  data_byte;

	modport source(output valid, command, opcode, payload_len, first, data_byte, input ready);
	modport sink(input valid, command, opcode, payload_len, first, data_byte, output ready);
endinterface

FILE: design/lpfb_out_if.sv
interface lpfb_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;
	logic       rejected;

	modport source(output valid, out_byte, out_last, rejected, input ready);
	modport sink(input valid, out_byte, out_last, rejected, output ready);
endinterface

FILE: design/lpfb_front.sv
module lpfb_front (
	input  logic            clk,
	input  logic            arst_n,
	lpfb_in_if.sink         items,
	input  logic            q_full,
	output logic            q_push,
	output lpfb_pkg::job_t  q_job
);
	import lpfb_pkg::*;

	logic [15:0] bytes_left_q;
	logic        in_frame_q;
	logic        discarding_q;

	logic        acc;
	logic        rej;
	logic [15:0] len;

	assign items.ready = !q_full;
	assign acc = items.valid && items.ready;
	assign len = items.payload_len;
	assign rej = (len > LEN_LIMIT) || (items.command && (len == 16'd0));

	always_comb begin
		q_job          = '0;
		q_job.opcode   = items.opcode;
		q_job.data     = items.data_byte;
		q_push         = 1'b0;
		if (items.first) begin
			q_push         = acc;
			q_job.jtype    = rej ? J_REJ : (items.command ? J_UNI : J_OPC);
			q_job.total    = len + (items.command ? UNI_OVERHEAD : OPC_OVERHEAD);
			q_job.has_data = (len != 16'd0);
			q_job.last     = (len <= 16'd1);
		end else begin
			q_job.jtype    = J_PAY;
			q_job.has_data = 1'b1;
			q_job.last     = (bytes_left_q == 16'd1);
			q_push         = acc && !discarding_q && in_frame_q && (bytes_left_q != 16'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= '0;
			in_frame_q   <= 1'b0;
			discarding_q <= 1'b0;
		end else if (acc) begin
			if (items.first) begin
				if (rej) begin
					in_frame_q   <= 1'b0;
					discarding_q <= (len > 16'd1);
					bytes_left_q <= (len > 16'd1) ? len - 16'd1 : 16'd0;
				end else begin
					discarding_q <= 1'b0;
					in_frame_q   <= (len > 16'd1);
					bytes_left_q <= (len != 16'd0) ? len - 16'd1 : 16'd0;
				end
			end else if (discarding_q) begin
				bytes_left_q <= bytes_left_q - 16'd1;
				discarding_q <= (bytes_left_q != 16'd1);
			end else if (in_frame_q && (bytes_left_q != 16'd0)) begin
				bytes_left_q <= bytes_left_q - 16'd1;
				in_frame_q   <= (bytes_left_q != 16'd1);
			end
		end
	end

endmodule

FILE: design/lpfb_queue.sv
`include "assert_macros.svh"
module lpfb_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  lpfb_pkg::job_t  push_job,
	output logic            full,
	input  logic            pop,
	output logic            avail,
	output lpfb_pkg::job_t  head
);
	import lpfb_pkg::*;

	job_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   count_q;

	assign full  = (count_q == (QAW+1)'(QDEPTH));
	assign avail = (count_q != '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`LPFB_NEVER(a_push_full, push && full, "job pushed into full queue")
	`LPFB_NEVER(a_pop_empty, pop && !avail, "job popped from empty queue")

endmodule

FILE: design/lpfb_back.sv
`include "assert_macros.svh"
module lpfb_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_avail,
	input  lpfb_pkg::job_t  q_head,
	output logic            q_pop,
	lpfb_out_if.source      frames
);
	import lpfb_pkg::*;

	typedef enum logic [2:0] {
		K_END,
		K_LENHI,
		K_LENLO,
		K_OPHI,
		K_OPLO,
		K_DATA,
		K_CSUM,
		K_REJ
	} kind_t;

	kind_t      cur_q;
	job_t       job_q;
	logic [7:0] sum_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       out_rej_q;

	logic       busy;
	logic       emit;
	logic       frame_start;
	kind_t      nxt_c;
	kind_t      after_hdr;
	kind_t      start_c;
	logic [7:0] byte_c;

	assign busy = (cur_q != K_END);
	assign emit = busy && (!out_valid_q || frames.ready);
	assign after_hdr = job_q.has_data ? K_DATA : K_CSUM;
	assign frame_start = ((cur_q == K_LENHI) && (job_q.jtype == J_OPC)) ||
		((cur_q == K_LENLO) && (job_q.jtype == J_UNI));

	always_comb begin
		byte_c = 8'h00;
		nxt_c  = K_END;
		unique case (cur_q)
			K_LENHI: begin
				byte_c = job_q.total[15:8];
				nxt_c  = (job_q.jtype == J_OPC) ? K_LENLO : after_hdr;
			end
			K_LENLO: begin
				byte_c = job_q.total[7:0];
				nxt_c  = (job_q.jtype == J_OPC) ? K_OPHI : K_LENHI;
			end
			K_OPHI: begin
				byte_c = job_q.opcode[15:8];
				nxt_c  = K_OPLO;
			end
			K_OPLO: begin
				byte_c = job_q.opcode[7:0];
				nxt_c  = after_hdr;
			end
			K_DATA: begin
				byte_c = job_q.data;
				nxt_c  = job_q.last ? K_CSUM : K_END;
			end
			K_CSUM: begin
				byte_c = 8'h00 - sum_q;
				nxt_c  = K_END;
			end
			K_REJ: begin
				byte_c = 8'h00;
				nxt_c  = K_END;
			end
			K_END: begin
				byte_c = 8'h00;
				nxt_c  = K_END;
			end
		endcase
	end

	always_comb begin
		unique case (q_head.jtype)
			J_OPC:   start_c = K_LENHI;
			J_UNI:   start_c = K_LENLO;
			J_PAY:   start_c = K_DATA;
			J_REJ:   start_c = K_REJ;
		endcase
	end

	// next job loads as the current one hands over its final word
	assign q_pop = q_avail && (!busy || (emit && (nxt_c == K_END)));

	assign frames.valid    = out_valid_q;
	assign frames.out_byte = out_byte_q;
	assign frames.out_last = out_last_q;
	assign frames.rejected = out_rej_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= K_END;
			job_q       <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			out_last_q  <= 1'b0;
			out_rej_q   <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				out_byte_q  <= byte_c;
				out_last_q  <= (cur_q == K_CSUM);
				out_rej_q   <= (cur_q == K_REJ);
				sum_q       <= frame_start ? byte_c : sum_q + byte_c;
			end else if (frames.ready) begin
				out_valid_q <= 1'b0;
			end
			if (q_pop) begin
				cur_q <= start_c;
				job_q <= q_head;
			end else if (emit) begin
				cur_q <= nxt_c;
			end
		end
	end

	`LPFB_NEVER(a_last_rej, out_valid_q && out_last_q && out_rej_q,
		"checksum word flagged as rejection")
	`LPFB_ASSERT(a_pop_done, q_pop |-> (!busy || emit), "job replaced before it finished")

endmodule

FILE: design/length_prefixed_frame_builder.sv
// Length-prefixed frame builder.
// items (valid/ready): one word per payload byte. The word with first = 1 opens
//   a frame and carries its kind (command), opcode, payload_len and, when
//   payload_len is not zero, the first payload byte.
// frames (valid/ready): one word per encoded frame byte. out_last marks the
//   checksum word; a rejected frame gives one word with rejected = 1, byte 0.
// Opcode frame: length+5 big-endian, opcode big-endian, payload, checksum.
// Universal frame: length+3 little-endian, payload, checksum.
// Structure: a classifier tracks frame position and drops stray or discarded
//   words, pushing jobs into a 4-entry queue; an expander turns each job into
//   frame bytes through a registered output stage.
// Path: an accepted word is queued, loaded into the expander, then registered.
// Throughput: one input word per cycle while the queue has room; the expander
//   emits one word per cycle while the receiver is ready, so a header word gives
//   up to 6 output words, a payload word one (two on the final byte). The queue
//   depth sets how much header overhead is absorbed before items.ready drops.
// Reset: queue empty, no frame open, nothing on the output.
// Receiver stall: the output word holds, the expander stops, the queue fills
//   and then items.ready goes low until words drain.
module length_prefixed_frame_builder (
	input  logic       clk,
	input  logic       arst_n,
	lpfb_in_if.sink    items,
	lpfb_out_if.source frames
);
	import lpfb_pkg::*;

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_avail;
	job_t push_job;
	job_t head_job;

	lpfb_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items),
		.q_full (q_full),
		.q_push (q_push),
		.q_job  (push_job)
	);

	lpfb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.full     (q_full),
		.pop      (q_pop),
		.avail    (q_avail),
		.head     (head_job)
	);

	lpfb_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_avail (q_avail),
		.q_head  (head_job),
		.q_pop   (q_pop),
		.frames  (frames)
	);

endmodule

FILE: dv/lpfb_tb_pkg.sv
package lpfb_tb_pkg;

	// frame kind as carried by the command field on the opening word
	typedef enum logic {
		FRAME_OPCODE    = 1'b0,
		FRAME_UNIVERSAL = 1'b1
	} frame_kind_t;

	// one encoded frame word as seen on the output channel
	typedef struct packed {
		logic [7:0] value;
		logic       last;
		logic       rejected;
	} frame_word_t;

endpackage

FILE: dv/lpfb_frame_checker.sv
module lpfb_frame_checker (
	input  logic clk,
	input  logic arst_n,
	lpfb_in_if   items,
	lpfb_out_if  frames,
	output int   errors,
	output int   pending,
	output int   words_out,
	output int   frames_closed,
	output int   rejections
);
	timeunit 1ns;
	timeprecision 1ps;

	import lpfb_pkg::*;
	import lpfb_tb_pkg::*;

	localparam int SHOW_LIMIT = 10;

	// predicted encoder state
	logic [15:0] payload_due;
	logic [7:0]  byte_sum;
	logic        frame_open;
	logic        dropping;

	frame_word_t frame_words_due[$];
	int          fail_count;
	int          out_count;
	int          close_count;
	int          reject_count;

	function automatic void emit_byte(logic [7:0] value, logic last);
		frame_word_t w;
		w.value    = value;
		w.last     = last;
		w.rejected = 1'b0;
		frame_words_due.push_back(w);
		byte_sum = byte_sum + value;
	endfunction

	// payload byte, plus the checksum once the last one is out
	function automatic void emit_payload(logic [7:0] value);
		emit_byte(value, 1'b0);
		payload_due = payload_due - 16'd1;
		if (payload_due == 16'd0) begin
			emit_byte(8'h00 - byte_sum, 1'b1);
			frame_open = 1'b0;
		end
	endfunction

	function automatic void predict_frame_words(frame_kind_t kind, logic [15:0] op,
			logic [15:0] len, logic first, logic [7:0] data);
		frame_word_t rej;
		logic [15:0] total;
		rej.value    = 8'h00;
		rej.last     = 1'b0;
		rej.rejected = 1'b1;
		if (first) begin
			frame_open  = 1'b0;
			dropping    = 1'b0;
			byte_sum    = 8'h00;
			payload_due = 16'd0;
			if (len > LEN_LIMIT || (kind == FRAME_UNIVERSAL && len == 16'd0)) begin
				frame_words_due.push_back(rej);
				if (len > 16'd1) begin
					payload_due = len - 16'd1;
					dropping    = 1'b1;
				end
				return;
			end
			if (kind == FRAME_OPCODE) begin
				total = len + OPC_OVERHEAD;
				emit_byte(total[15:8], 1'b0);
				emit_byte(total[7:0], 1'b0);
				emit_byte(op[15:8], 1'b0);
				emit_byte(op[7:0], 1'b0);
			end else begin
				total = len + UNI_OVERHEAD;
				emit_byte(total[7:0], 1'b0);
				emit_byte(total[15:8], 1'b0);
			end
			if (len == 16'd0) begin
				emit_byte(8'h00 - byte_sum, 1'b1);
				return;
			end
			payload_due = len;
			frame_open  = 1'b1;
			emit_payload(data);
			return;
		end
		if (dropping) begin
			payload_due = payload_due - 16'd1;
			if (payload_due == 16'd0)
				dropping = 1'b0;
			return;
		end
		if (frame_open && payload_due != 16'd0)
			emit_payload(data);
	endfunction

	function automatic void check_frame_word(frame_word_t got);
		frame_word_t want;
		if (frame_words_due.size() == 0) begin
			fail_count++;
			if (fail_count <= SHOW_LIMIT)
				$display("[%0t] unexpected frame word: byte %02h last %b rejected %b",
					$time, got.value, got.last, got.rejected);
			return;
		end
		want = frame_words_due.pop_front();
		if (want.value !== got.value || want.last !== got.last
				|| want.rejected !== got.rejected) begin
			fail_count++;
			if (fail_count <= SHOW_LIMIT)
				$display("[%0t] frame word mismatch: expected byte %02h last %b rej %b, %s",
					$time, want.value, want.last, want.rejected,
					$sformatf("got byte %02h last %b rej %b",
						got.value, got.last, got.rejected));
		end
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			payload_due = 16'd0;
			byte_sum    = 8'h00;
			frame_open  = 1'b0;
			dropping    = 1'b0;
			frame_words_due.delete();
		end else begin
			// output first: a word leaving now never stems from a word entering now
			if (frames.valid && frames.ready) begin
				check_frame_word({frames.out_byte, frames.out_last, frames.rejected});
				out_count++;
				if (frames.out_last)
					close_count++;
				if (frames.rejected)
					reject_count++;
			end
			if (items.valid && items.ready)
				predict_frame_words(frame_kind_t'(items.command), items.opcode,
					items.payload_len, items.first, items.data_byte);
		end
		pending       <= frame_words_due.size();
		errors        <= fail_count;
		words_out     <= out_count;
		frames_closed <= close_count;
		rejections    <= reject_count;
	end

	initial begin
		fail_count   = 0;
		out_count    = 0;
		close_count  = 0;
		reject_count = 0;
	end

endmodule

FILE: dv/length_prefixed_frame_builder_tb.sv
module length_prefixed_frame_builder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lpfb_pkg::*;
	import lpfb_tb_pkg::*;

	localparam int RESET_CYCLES  = 12;
	localparam int RANDOM_WORDS  = 205;
	localparam int MAX_WAIT      = 14;
	localparam int TAIL_CYCLES   = 10;    // idle margin after the final drain
	localparam int QUIET_LIMIT   = 1000;  // cycles with no word moving on either side

	logic clk;
	logic arst_n;

	lpfb_in_if  items();
	lpfb_out_if frames();

	int  errors;
	int  pending;
	int  words_out;
	int  frames_closed;
	int  rejections;
	int  words_sent;

	// per-side idling switches; off gives back-to-back stretches
	bit  src_gaps_on;
	bit  sink_stalls_on;

	length_prefixed_frame_builder dut (
		.clk   (clk),
		.arst_n(arst_n),
		.items (items),
		.frames(frames)
	);

	lpfb_frame_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.items        (items),
		.frames       (frames),
		.errors       (errors),
		.pending      (pending),
		.words_out    (words_out),
		.frames_closed(frames_closed),
		.rejections   (rejections)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Sends one word. Called at a rising edge; returns at the edge that took it.
	// valid gets a single assignment per step: it is lowered only for a gap.
	task automatic send_word(frame_kind_t kind, logic [15:0] op, logic [15:0] len,
			logic first, logic [7:0] data);
		int gap;
		gap = src_gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
		if (gap > 0) begin
			items.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		items.valid       <= 1'b1;
		items.command     <= kind;
		items.opcode      <= op;
		items.payload_len <= len;
		items.first       <= first;
		items.data_byte   <= data;
		do
			@(posedge clk);
		while (!items.ready);
		words_sent++;
	endtask

	// Opening word plus n_words-1 follow-ups. The follow-ups carry random
	// kind/opcode/length, which the block has to ignore. n_words below the
	// length abandons the frame; above it the extra words are strays.
	task automatic send_frame(frame_kind_t kind, logic [15:0] op, logic [15:0] len,
			int n_words, logic [7:0] first_data);
		send_word(kind, op, len, 1'b1, first_data);
		for (int i = 1; i < n_words; i++)
			send_word(frame_kind_t'($urandom_range(0, 1)), 16'($urandom),
				16'($urandom), 1'b0, 8'($urandom));
	endtask

	// Hold off the source until every predicted word has come out.
	// pending is registered, so always step past the accepting edge first.
	task automatic drain_frames();
		items.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	// output side: random stall before each word
	initial begin : frame_sink
		int stall;
		frames.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = sink_stalls_on ? $urandom_range(0, MAX_WAIT) : 0;
			if (stall > 0) begin
				frames.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			frames.ready <= 1'b1;
			do
				@(posedge clk);
			while (!frames.valid);
		end
	end

	// ends the run if nothing moves on either channel for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		wait (arst_n);
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((items.valid && items.ready) || (frames.valid && frames.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no word moved for %0d cycles, %0d still expected",
			QUIET_LIMIT, pending);
		$display("TB_ERROR");
		$finish;
	end

	initial begin : stimulus
		int          base;
		int          pick;
		int          n;
		bit          paused;
		frame_kind_t kind;
		logic [15:0] len;

		words_sent        = 0;
		paused            = 1'b0;
		src_gaps_on       = 1'b1;
		sink_stalls_on    = 1'b1;
		arst_n            = 1'b0;
		items.valid       <= 1'b0;
		items.command     <= FRAME_OPCODE;
		items.opcode      <= 16'h0000;
		items.payload_len <= 16'h0000;
		items.first       <= 1'b0;
		items.data_byte   <= 8'h00;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed ----
		// empty opcode frame: header + checksum at once, data byte ignored
		send_frame(FRAME_OPCODE, 16'hFFFF, 16'd0, 1, 8'hFF);
		// empty universal frame is rejected
		send_frame(FRAME_UNIVERSAL, 16'hFFFF, 16'd0, 1, 8'hFF);
		// one past the length limit: rejected, following words dropped,
		// then a new opening word cuts the drop short
		send_frame(FRAME_OPCODE, 16'h0000, LEN_LIMIT + 16'd1, 3, 8'h00);
		// all-ones length, rejected
		send_frame(FRAME_UNIVERSAL, 16'h1234, 16'hFFFF, 2, 8'h55);
		// single payload byte, both kinds (opcode one gives the most words)
		send_frame(FRAME_UNIVERSAL, 16'h0000, 16'd1, 1, 8'hFF);
		send_frame(FRAME_OPCODE, 16'h0000, 16'd1, 1, 8'h00);
		send_frame(FRAME_OPCODE, 16'hA5A5, 16'd3, 3, 8'h80);
		// abandoned mid-frame by a new opening word
		send_frame(FRAME_UNIVERSAL, 16'h5A5A, 16'd4, 2, 8'h7F);
		// exactly at the length limit, both kinds, abandoned after two bytes
		send_frame(FRAME_OPCODE, 16'h8001, LEN_LIMIT, 2, 8'h01);
		send_frame(FRAME_UNIVERSAL, 16'h0000, LEN_LIMIT, 2, 8'hFE);
		// complete frame, then two strays outside any frame
		send_frame(FRAME_OPCODE, 16'h00FF, 16'd2, 4, 8'hC3);
		drain_frames();

		// ---- random ----
		base = words_sent;
		while (words_sent - base < RANDOM_WORDS) begin
			src_gaps_on    = ($urandom_range(0, 3) != 0);
			sink_stalls_on = ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 99);
			kind = frame_kind_t'($urandom_range(0, 1));
			if (pick < 5) begin
				send_frame(FRAME_OPCODE, 16'($urandom), 16'd0, 1, 8'($urandom));
			end else if (pick < 70) begin
				// mostly short frames, some mid-sized, a few abandoned
				if ($urandom_range(0, 9) == 0)
					len = 16'($urandom_range(9, 40));
				else
					len = 16'($urandom_range(1, 8));
				n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, int'(len)) : int'(len);
				send_frame(kind, 16'($urandom), len, n, 8'($urandom));
			end else if (pick < 82) begin
				// rejected: too long or empty universal, with a few dropped words
				if ($urandom_range(0, 2) == 0)
					send_frame(FRAME_UNIVERSAL, 16'($urandom), 16'd0,
						$urandom_range(1, 3), 8'($urandom));
				else
					send_frame(kind, 16'($urandom),
						16'($urandom_range(int'(LEN_LIMIT) + 1, 65535)),
						$urandom_range(1, 4), 8'($urandom));
			end else if (pick < 90) begin
				// words without an opening word
				n = $urandom_range(1, 3);
				repeat (n)
					send_word(kind, 16'($urandom), 16'($urandom), 1'b0, 8'($urandom));
			end else begin
				// long frame, only its head is sent
				send_frame(kind, 16'($urandom), 16'($urandom_range(100, int'(LEN_LIMIT))),
					$urandom_range(1, 4), 8'($urandom));
			end
			if (!paused && words_sent - base >= RANDOM_WORDS / 2) begin
				drain_frames();
				paused = 1'b1;
			end
		end

		drain_frames();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("run: %0d input words, %0d frame words checked, %0d frames closed, %0d rejected",
			words_sent, words_out, frames_closed, rejections);
		if (errors == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+design
design/lpfb_pkg.sv
design/lpfb_in_if.sv
design/lpfb_out_if.sv
design/lpfb_front.sv
design/lpfb_queue.sv
design/lpfb_back.sv
design/length_prefixed_frame_builder.sv
dv/lpfb_tb_pkg.sv
dv/lpfb_frame_checker.sv
dv/length_prefixed_frame_builder_tb.sv
